>>> sv/bff_pkg.sv
`default_nettype none
package bff_pkg;

	localparam int CHUNK_COUNT_DEF = 65536;
	localparam int CHUNK_BYTES = 64;
	localparam int WORD_BITS = 64;
	localparam int MIN_ALIGN_LOG2 = 6;
	localparam int ACT_W = 2;
	localparam int OFFSET_W = 22;
	localparam int COUNT_W = 23;
	localparam int ALIGN_W = 5;
	localparam int ADDR_W = 22;
	localparam int TOP_W = 23;
	localparam int RUN_W = 27;

	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MARK = 2'd1;
	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd2;
	localparam logic [ACT_W-1:0] ACT_TOP = 2'd3;

	typedef struct packed {
		logic       lo_any;
		logic [5:0] lo_idx;
		logic       hi_any;
		logic [5:0] hi_idx;
	} find_t;

	// bits lo .. hi-1 set, hi may be 64
	function automatic logic [WORD_BITS-1:0] run_mask(input logic [5:0] lo, input logic [6:0] hi);
		logic [WORD_BITS-1:0] m;
		m = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			m[b] = (7'(b) >= {1'b0, lo}) && (7'(b) < hi);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

>>> sv/bitmap_first_fit_allocator.sv
`default_nettype none
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+--------------------------
// command   | action byte_offset byte_count align_log2       | start and not busy
// result    | address ok top_end                             | done, one cycle, no stall
//
// the map sits in one ram of 64-bit words, one read or write per cycle,
// read data registered. mark: read and write back each word touched. top:
// read and check each word, scanned down from the end. allocate: read each word
// for the hint walk and search, check again per clash inside a word, then the mark.
// clear and reset sweep every word, busy throughout.
// results cannot be held off; a new word is taken on the cycle done shows.
module bitmap_first_fit_allocator
	import bff_pkg::*;
#(
	parameter int CHUNK_COUNT = CHUNK_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [ACT_W-1:0]    action,
	input  wire logic [OFFSET_W-1:0] byte_offset,
	input  wire logic [COUNT_W-1:0]  byte_count,
	input  wire logic [ALIGN_W-1:0]  align_log2,
	output logic                     done,
	output logic [ADDR_W-1:0]        address,
	output logic                     ok,
	output logic [TOP_W-1:0]         top_end
);
	localparam int WORDS = (CHUNK_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WAW = WORDS > 1 ? $clog2(WORDS) : 1;
	localparam int HW = $clog2(CHUNK_COUNT);
	localparam logic [RUN_W-1:0] N_R = RUN_W'(CHUNK_COUNT);
	localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_MK_ST, S_MK_RD, S_MK_WR, S_HINT_RD, S_HINT_EV,
		S_AL_ST, S_SR_RD, S_SR_EV, S_TOP_RD, S_TOP_EV
	} state_t;

	state_t            state_q;
	logic [ACT_W-1:0]  act_q;
	logic              report_q;
	logic [WAW-1:0]    word_q;
	logic [RUN_W-1:0]  first_q, end_q, cand_q, pos_q, n_q;
	logic [4:0]        sh_q;
	logic [HW-1:0]     hint_q;
	logic              done_q, ok_q;
	logic [ADDR_W-1:0] address_q;
	logic [TOP_W-1:0]  top_end_q;

	logic              ram_we, ram_re;
	logic [WORD_BITS-1:0] ram_wdata, rdata;
	logic [WORD_BITS-1:0] find_vec;
	find_t             fnd;

	logic [RUN_W-1:0]  base, base_end, last_c, lim, hint_r, j_c, cand_nx, i0, c_top;
	logic [5:0]        mk_lo;
	logic [6:0]        mk_hi, sr_hi;
	logic [WORD_BITS-1:0] mk_mask, sr_used, hint_free;
	logic [4:0]        lgc;
	logic [31:0]       cnt_w, q_w, rem_m;
	logic [RUN_W-1:0]  n_new, mk_first, mk_end;
	logic [23:0]       mk_sum;

	bff_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_map (
		.clk(clk), .we(ram_we), .waddr(word_q), .wdata(ram_wdata),
		.re(ram_re), .raddr(word_q), .rdata(rdata)
	);

	bff_bitfind u_find (.vec(find_vec), .res(fnd));

	always_comb begin
		base = RUN_W'({word_q, 6'b0});
		base_end = base + RUN_W'(WORD_BITS);
		last_c = end_q - RUN_W'(1);
		mk_lo = (word_q == first_q[WAW+5:6]) ? first_q[5:0] : 6'd0;
		mk_hi = (word_q == last_c[WAW+5:6]) ? ({1'b0, last_c[5:0]} + 7'd1) : 7'd64;
		mk_mask = run_mask(mk_lo, mk_hi);
		lim = cand_q + n_q;
		sr_hi = (lim >= base_end) ? 7'd64 : 7'(lim - base);
		sr_used = rdata & run_mask(pos_q[5:0], sr_hi);
		hint_r = RUN_W'(hint_q);
		hint_free = ~rdata & run_mask(hint_r[5:0], 7'd64);
		case (state_q)
			S_HINT_EV: find_vec = hint_free;
			S_SR_EV:   find_vec = sr_used;
			default:   find_vec = rdata;
		endcase
		j_c = base + RUN_W'(fnd.lo_idx);
		cand_nx = ((j_c >> sh_q) + RUN_W'(1)) << sh_q;
		i0 = (hint_r >> sh_q) << sh_q;
		c_top = base + RUN_W'(fnd.hi_idx) + RUN_W'(1);
		lgc = (align_log2 < 5'(MIN_ALIGN_LOG2)) ? 5'(MIN_ALIGN_LOG2) : align_log2;
		cnt_w = 32'(byte_count);
		q_w = cnt_w >> lgc;
		rem_m = (32'd1 << lgc) - 32'd1;
		n_new = RUN_W'(q_w + 32'(|(cnt_w & rem_m))) << (lgc - 5'(MIN_ALIGN_LOG2));
		mk_sum = 24'(byte_offset) + 24'(byte_count) + 24'(CHUNK_BYTES - 1);
		mk_first = RUN_W'(byte_offset[OFFSET_W-1:6]);
		mk_end = RUN_W'(mk_sum[23:6]);
		if (mk_end > N_R) begin
			mk_end = N_R;
		end
		ram_we = (state_q == S_CLR) || (state_q == S_MK_WR);
		ram_wdata = (state_q == S_CLR) ? '0 : (rdata | mk_mask);
		ram_re = (state_q == S_MK_RD) || (state_q == S_HINT_RD) ||
			(state_q == S_SR_RD) || (state_q == S_TOP_RD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			report_q <= 1'b0;
			word_q <= '0;
			hint_q <= '0;
			done_q <= 1'b0;
			act_q <= ACT_CLEAR;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					if (word_q == LAST_WORD) begin
						state_q <= S_IDLE;
						if (report_q) begin
							done_q <= 1'b1;
							ok_q <= 1'b1;
							address_q <= '0;
							top_end_q <= '0;
						end
					end else begin
						word_q <= word_q + WAW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						act_q <= action;
						case (action)
							ACT_CLEAR: begin
								word_q <= '0;
								report_q <= 1'b1;
								hint_q <= '0;
								state_q <= S_CLR;
							end
							ACT_MARK: begin
								first_q <= mk_first;
								end_q <= mk_end;
								state_q <= S_MK_ST;
							end
							ACT_ALLOC: begin
								n_q <= n_new;
								sh_q <= lgc - 5'(MIN_ALIGN_LOG2);
								word_q <= hint_r[WAW+5:6];
								state_q <= S_HINT_RD;
							end
							default: begin
								word_q <= LAST_WORD;
								state_q <= S_TOP_RD;
							end
						endcase
					end
				end
				S_MK_ST: begin
					if (end_q <= first_q) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						ok_q <= 1'b1;
						address_q <= (act_q == ACT_ALLOC) ? {cand_q[ADDR_W-7:0], 6'b0} : '0;
						top_end_q <= '0;
					end else begin
						word_q <= first_q[WAW+5:6];
						state_q <= S_MK_RD;
					end
				end
				S_MK_RD: state_q <= S_MK_WR;
				S_MK_WR: begin
					if (word_q == last_c[WAW+5:6]) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						ok_q <= 1'b1;
						address_q <= (act_q == ACT_ALLOC) ? {cand_q[ADDR_W-7:0], 6'b0} : '0;
						top_end_q <= '0;
					end else begin
						word_q <= word_q + WAW'(1);
						state_q <= S_MK_RD;
					end
				end
				S_HINT_RD: state_q <= S_HINT_EV;
				S_HINT_EV: begin
					if (fnd.lo_any) begin
						hint_q <= (j_c >= N_R) ? HW'(CHUNK_COUNT - 1) : HW'(j_c);
						state_q <= S_AL_ST;
					end else if (base_end >= N_R) begin
						hint_q <= HW'(CHUNK_COUNT - 1);
						state_q <= S_AL_ST;
					end else begin
						hint_q <= HW'(base_end);
						word_q <= word_q + WAW'(1);
						state_q <= S_HINT_RD;
					end
				end
				S_AL_ST: begin
					cand_q <= i0;
					pos_q <= i0;
					word_q <= i0[WAW+5:6];
					if (i0 + n_q > N_R) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						ok_q <= 1'b0;
						address_q <= '0;
						top_end_q <= '0;
					end else if (n_q == '0) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						ok_q <= 1'b1;
						address_q <= {i0[ADDR_W-7:0], 6'b0};
						top_end_q <= '0;
					end else begin
						state_q <= S_SR_RD;
					end
				end
				S_SR_RD: state_q <= S_SR_EV;
				S_SR_EV: begin
					if (!fnd.lo_any) begin
						if (lim <= base_end) begin
							first_q <= cand_q;
							end_q <= lim;
							state_q <= S_MK_ST;
						end else begin
							pos_q <= base_end;
							word_q <= word_q + WAW'(1);
							state_q <= S_SR_RD;
						end
					end else begin
						cand_q <= cand_nx;
						pos_q <= cand_nx;
						if (cand_nx + n_q > N_R) begin
							state_q <= S_IDLE;
							done_q <= 1'b1;
							ok_q <= 1'b0;
							address_q <= '0;
							top_end_q <= '0;
						end else if ((cand_nx >> 6) != (base >> 6)) begin
							word_q <= cand_nx[WAW+5:6];
							state_q <= S_SR_RD;
						end
					end
				end
				S_TOP_RD: state_q <= S_TOP_EV;
				S_TOP_EV: begin
					if (fnd.hi_any || word_q == '0) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						ok_q <= 1'b1;
						address_q <= '0;
						top_end_q <= fnd.hi_any ? {c_top[TOP_W-7:0], 6'b0} : '0;
					end else begin
						word_q <= word_q - WAW'(1);
						state_q <= S_TOP_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign ok = ok_q;
	assign address = address_q;
	assign top_end = top_end_q;

	a_one_shot: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("word accepted but not busy");
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> address == '0 && top_end == '0)
		else $error("failed allocation carries data");
	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n) !(ram_we && ram_re))
		else $error("map read and written together");
endmodule
`default_nettype wire

>>> sv/bff_ram.sv
`default_nettype none
module bff_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> sv/bff_bitfind.sv
`default_nettype none
module bff_bitfind
	import bff_pkg::*;
(
	input  wire logic [WORD_BITS-1:0] vec,
	output find_t                     res
);
	always_comb begin
		res = '0;
		res.lo_any = |vec;
		res.hi_any = |vec;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (vec[b]) begin
				res.lo_idx = 6'(b);
			end
		end
		for (int b = 0; b < WORD_BITS; b++) begin
			if (vec[b]) begin
				res.hi_idx = 6'(b);
			end
		end
	end
endmodule
`default_nettype wire

>>> tb/tb_bitmap_first_fit_allocator.sv
`default_nettype none
module tb_bitmap_first_fit_allocator
	import bff_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_CHUNKS = CHUNK_COUNT_DEF;
	localparam int STALL_LIMIT = 400000;
	localparam longint ADDR_MASK = (64'd1 << ADDR_W) - 1;
	localparam longint TOP_MASK = (64'd1 << TOP_W) - 1;

	typedef struct {
		logic [ADDR_W-1:0] address;
		logic              ok;
		logic [TOP_W-1:0]  top_end;
	} result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [ACT_W-1:0]    action;
	logic [OFFSET_W-1:0] byte_offset;
	logic [COUNT_W-1:0]  byte_count;
	logic [ALIGN_W-1:0]  align_log2;
	logic                done;
	logic [ADDR_W-1:0]   address;
	logic                ok;
	logic [TOP_W-1:0]    top_end;

	bit      used_map [N_CHUNKS];
	longint  free_hint;
	result_t pending_results [$];
	int      errors;
	int      words_checked;
	int      allocs_ok;
	int      allocs_failed;
	int      stall_cycles;
	bit      idle_on;

	bitmap_first_fit_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.byte_offset(byte_offset),
		.byte_count(byte_count),
		.align_log2(align_log2),
		.done(done),
		.address(address),
		.ok(ok),
		.top_end(top_end)
	);

	always #10 clk = ~clk;

	task automatic mark_range(input longint first, input longint last);
		longint c;
		if (last > N_CHUNKS) last = N_CHUNKS;
		for (c = first; c < last; c++) used_map[int'(c)] = 1'b1;
	endtask

	task automatic predict_word(input logic [ACT_W-1:0] act, input longint off,
			input longint cnt, input longint lg, output result_t r);
		longint ab, ach, n, i, j;
		bit clash;
		r.address = '0;
		r.ok = 1'b1;
		r.top_end = '0;
		case (act)
			ACT_CLEAR: begin
				used_map = '{default: 1'b0};
				free_hint = 0;
			end
			ACT_MARK: begin
				mark_range(off / CHUNK_BYTES, (off + cnt + CHUNK_BYTES - 1) / CHUNK_BYTES);
			end
			ACT_ALLOC: begin
				if (lg < MIN_ALIGN_LOG2) lg = MIN_ALIGN_LOG2;
				ab = longint'(1) << lg;
				ach = ab / CHUNK_BYTES;
				n = ((cnt + ab - 1) / ab) * ab / CHUNK_BYTES;
				while (free_hint + 1 < N_CHUNKS && used_map[int'(free_hint)]) free_hint++;
				i = (free_hint / ach) * ach;
				r.ok = 1'b0;
				while (i < N_CHUNKS && i + n <= N_CHUNKS) begin
					clash = 0;
					for (j = i; j < i + n; j++) begin
						if (used_map[int'(j)]) begin
							clash = 1;
							break;
						end
					end
					if (!clash) begin
						mark_range(i, i + n);
						r.ok = 1'b1;
						r.address = ADDR_W'((i * CHUNK_BYTES) & ADDR_MASK);
						break;
					end
					i = (j / ach + 1) * ach;
				end
				if (r.ok) allocs_ok++;
				else allocs_failed++;
			end
			default: begin
				j = N_CHUNKS;
				while (j > 0 && !used_map[int'(j - 1)]) j--;
				r.top_end = TOP_W'((j * CHUNK_BYTES) & TOP_MASK);
			end
		endcase
	endtask

	task automatic send_word(input logic [ACT_W-1:0] act, input longint off,
			input longint cnt, input longint lg);
		result_t r;
		@(negedge clk);
		if (idle_on && $urandom_range(99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		byte_offset <= OFFSET_W'(off);
		byte_count <= COUNT_W'(cnt);
		align_log2 <= ALIGN_W'(lg);
		do @(posedge clk); while (busy);
		predict_word(act, off, cnt, lg, r);
		pending_results.push_back(r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin
		result_t e;
		if (done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result word with none expected: address %h ok %b top_end %h",
					$time, address, ok, top_end);
				errors++;
			end else begin
				e = pending_results.pop_front();
				words_checked++;
				if (address !== e.address) begin
					$display("%0t: address expected %h actual %h", $time, e.address, address);
					errors++;
				end
				if (ok !== e.ok) begin
					$display("%0t: ok expected %b actual %b", $time, e.ok, ok);
					errors++;
				end
				if (top_end !== e.top_end) begin
					$display("%0t: top_end expected %h actual %h", $time, e.top_end, top_end);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic test_directed();
		send_word(ACT_TOP, 0, 0, 6);
		send_word(ACT_MARK, 0, 0, 6);
		send_word(ACT_TOP, 4194303, 4194304, 31);
		send_word(ACT_ALLOC, 0, 0, 0);
		send_word(ACT_ALLOC, 0, 4194304, 22);
		send_word(ACT_TOP, 0, 0, 6);
		send_word(ACT_ALLOC, 0, 64, 6);
		send_word(ACT_CLEAR, 4194303, 4194304, 31);
		send_word(ACT_MARK, 0, 256, 6);
		send_word(ACT_ALLOC, 0, 64, 6);
		send_word(ACT_ALLOC, 0, 1, 3);
		send_word(ACT_ALLOC, 0, 100, 9);
		send_word(ACT_ALLOC, 0, 0, 31);
		send_word(ACT_ALLOC, 0, 1, 31);
		send_word(ACT_MARK, 4194303, 4194304, 0);
		send_word(ACT_TOP, 0, 0, 6);
		send_word(ACT_ALLOC, 0, 2097152, 21);
		send_word(ACT_ALLOC, 0, 4194304, 6);
		send_word(ACT_CLEAR, 0, 0, 0);
		send_word(ACT_MARK, 4194240, 64, 6);
		send_word(ACT_ALLOC, 0, 4194240, 6);
		send_word(ACT_ALLOC, 0, 64, 6);
		send_word(ACT_TOP, 0, 0, 6);
		send_word(ACT_CLEAR, 0, 0, 6);
	endtask

	task automatic test_drain_pause();
		wait_drained();
		send_word(ACT_ALLOC, 0, 4096, 12);
		wait_drained();
	endtask

	task automatic test_random(input int count);
		int k, pick;
		longint off, cnt, lg;
		for (k = 0; k < count; k++) begin
			idle_on = !(k >= 200 && k < 500);
			pick = $urandom_range(99);
			off = $urandom_range(4194303, 0);
			cnt = $urandom_range(4096, 0);
			lg = $urandom_range(12, 6);
			if ($urandom_range(19) == 0) begin
				cnt = $urandom_range(4194304, 0);
				lg = $urandom_range(31, 0);
			end
			if ($urandom_range(3) == 0) off = $urandom_range(262143, 0);
			if (pick < 4) send_word(ACT_CLEAR, off, cnt, lg);
			else if (pick < 8) send_word(ACT_TOP, off, cnt, lg);
			else if (pick < 30) send_word(ACT_MARK, off, cnt, lg);
			else send_word(ACT_ALLOC, off, cnt, lg);
		end
		idle_on = 1;
	endtask

	initial begin
		int guard;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_CLEAR;
		byte_offset = '0;
		byte_count = '0;
		align_log2 = '0;
		errors = 0;
		words_checked = 0;
		allocs_ok = 0;
		allocs_failed = 0;
		stall_cycles = 0;
		idle_on = 1;
		free_hint = 0;
		used_map = '{default: 1'b0};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_drain_pause();
		test_random(600);
		test_drain_pause();
		test_random(600);
		wait_drained();
		guard = 0;
		while (guard < 100) begin
			@(posedge clk);
			guard++;
		end
		$display("checked %0d result words: %0d allocations placed, %0d refused",
			words_checked, allocs_ok, allocs_failed);
		$display("covered clear, mark, allocate and top with extreme and random fields");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
sv/bff_pkg.sv
sv/bff_ram.sv
sv/bff_bitfind.sv
sv/bitmap_first_fit_allocator.sv
tb/tb_bitmap_first_fit_allocator.sv
